[sv/socd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCD neutralizer package
// Shared codes, the reset constant and the item and result types.
// ----------------------------------------------------------------------------
package socd_pkg;

  localparam logic [15:0] HOLDOFF_RESET = 16'd1000;

  localparam logic OP_KEY    = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [1:0] TS_NONE     = 2'd0;
  localparam logic [1:0] TS_ACCEPTED = 2'd1;
  localparam logic [1:0] TS_IGNORED  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [2:0]  key_index;
    logic        key_down;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] action_key;
    logic       handled;
    logic [1:0] toggle_status;
    logic       enabled;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } res_pair_t;

endpackage

[sv/socd_last_input_wins.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCD last-input-wins neutralizer
// Resolves opposing key pairs and toggles neutralization with a holdoff.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Beat contents
// in_       input      in_valid/in_stall  operation, key_index, key_down, now_ms
// out_      output     out_valid/out_stall action, key, handled, toggle, enabled, last
// cfg_      input      cfg_wr_en          toggle holdoff in milliseconds
//
// An item is processed once it is registered and the result buffer can take
// it, and gives one or two result beats.
// The result buffer loads the next item while its final beat goes out.
// Reset is synchronous and active low; the holdoff returns to 1000 ms.
// Stalls on the result side back up into in_stall with no loss of beats.
// ----------------------------------------------------------------------------
module socd_last_input_wins
  import socd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [2:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [1:0]  out_action_key,
  output logic        out_handled,
  output logic [1:0]  out_toggle_status,
  output logic        out_enabled,
  output logic        out_last_result
);

  logic      item_valid;
  item_t     item;
  logic      can_load;
  logic      fire;
  res_pair_t pair;

  assign fire = item_valid && can_load;

  socd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_key_down  (in_key_down),
    .in_now_ms    (in_now_ms),
    .take         (fire),
    .item_valid   (item_valid),
    .item         (item)
  );

  socd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .pair        (pair)
  );

  socd_out_buf u_out_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (fire),
    .pair              (pair),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_action_key    (out_action_key),
    .out_handled       (out_handled),
    .out_toggle_status (out_toggle_status),
    .out_enabled       (out_enabled),
    .out_last_result   (out_last_result)
  );

endmodule

[sv/socd_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCD input register
// Holds one input beat until the core takes it.
// ----------------------------------------------------------------------------
module socd_in_reg
  import socd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [2:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [31:0] in_now_ms,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign valid_nxt  = accept || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r.operation <= in_operation;
      item_r.key_index <= in_key_index;
      item_r.key_down  <= in_key_down;
      item_r.now_ms    <= in_now_ms;
    end
  end

endmodule

[sv/socd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCD core
// Key state, enable flag and toggle holdoff; computes one or two results.
// ----------------------------------------------------------------------------
module socd_core
  import socd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        fire,
  input  item_t       item,
  output res_pair_t   pair
);

  logic [3:0]  held_r, held_nxt;
  logic [3:0]  supp_r, supp_nxt;
  logic        en_r, en_nxt;
  logic [31:0] last_ms_r, last_ms_nxt;
  logic [15:0] holdoff_r;
  logic [31:0] elapsed;
  logic [1:0]  k;
  logic [1:0]  opp;
  result_t     r0;
  result_t     r1;
  logic        two;

  always_comb begin
    held_nxt    = held_r;
    supp_nxt    = supp_r;
    en_nxt      = en_r;
    last_ms_nxt = last_ms_r;
    elapsed     = item.now_ms - last_ms_r;
    k           = item.key_index[1:0];
    opp         = k ^ 2'd1;
    r0          = '0;
    r1          = '0;
    two         = 1'b0;
    if (item.operation == OP_TOGGLE) begin
      r0.handled = 1'b1;
      if (elapsed < {16'd0, holdoff_r}) begin
        r0.toggle_status = TS_IGNORED;
      end else begin
        r0.toggle_status = TS_ACCEPTED;
        last_ms_nxt      = item.now_ms;
        en_nxt           = !en_r;
      end
    end else if (item.key_index[2]) begin
      r0 = '0;
    end else if (item.key_down) begin
      held_nxt[k] = 1'b1;
      supp_nxt[k] = 1'b0;
      if (en_r && held_r[opp] && !supp_r[opp]) begin
        supp_nxt[opp]  = 1'b1;
        two            = 1'b1;
        r0.action      = ACT_RELEASE;
        r0.action_key  = opp;
        r0.handled     = 1'b1;
        r1.action      = ACT_PRESS;
        r1.action_key  = k;
        r1.handled     = 1'b1;
      end else begin
        r0.action     = ACT_PRESS;
        r0.action_key = k;
        r0.handled    = 1'b1;
      end
    end else begin
      held_nxt[k]   = 1'b0;
      r0.action_key = k;
      r0.handled    = 1'b1;
      if (supp_r[k]) begin
        supp_nxt[k] = 1'b0;
        r0.action   = ACT_NONE;
      end else begin
        r0.action = ACT_RELEASE;
        if (held_r[opp] && supp_r[opp]) begin
          supp_nxt[opp] = 1'b0;
          two           = 1'b1;
          r1.action     = ACT_PRESS;
          r1.action_key = opp;
          r1.handled    = 1'b1;
        end
      end
    end
    r0.enabled     = en_nxt;
    r1.enabled     = en_nxt;
    r0.last_result = !two;
    r1.last_result = 1'b1;
  end

  assign pair.two    = two;
  assign pair.first  = r0;
  assign pair.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      supp_r    <= '0;
      en_r      <= 1'b1;
      last_ms_r <= '0;
      holdoff_r <= HOLDOFF_RESET;
    end else begin
      if (cfg_wr_en) begin
        holdoff_r <= cfg_wr_data;
      end
      if (fire) begin
        held_r    <= held_nxt;
        supp_r    <= supp_nxt;
        en_r      <= en_nxt;
        last_ms_r <= last_ms_nxt;
      end
    end
  end

  // A suppressed key is always a held key.
  a_supp_held: assert property (@(posedge clk) disable iff (!rst_n)
    (supp_r & ~held_r) == 4'd0)
    else $error("suppressed key not held");

  // At most one key of each pair is suppressed.
  a_pair_supp: assert property (@(posedge clk) disable iff (!rst_n)
    !(supp_r[0] && supp_r[1]) && !(supp_r[2] && supp_r[3]))
    else $error("both keys of a pair suppressed");

  // Key state does not move without a processed beat.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(held_r) && $stable(supp_r) && $stable(en_r))
    else $error("key state changed without a beat");

endmodule

[sv/socd_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCD result buffer
// Holds the one or two results of an item and hands them out in order.
// ----------------------------------------------------------------------------
module socd_out_buf
  import socd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_pair_t  pair,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_action,
  output logic [1:0] out_action_key,
  output logic       out_handled,
  output logic [1:0] out_toggle_status,
  output logic       out_enabled,
  output logic       out_last_result
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    res0_r;
  result_t    res1_r;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = pair.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (load) begin
      res0_r <= pair.first;
      res1_r <= pair.second;
    end else if (pop && cnt_r == 2'd2) begin
      res0_r <= res1_r;
    end
  end

  assign out_action        = res0_r.action;
  assign out_action_key    = res0_r.action_key;
  assign out_handled       = res0_r.handled;
  assign out_toggle_status = res0_r.toggle_status;
  assign out_enabled       = res0_r.enabled;
  assign out_last_result   = res0_r.last_result;

  // The beat on show is the last of its item exactly when one is left.
  a_last_one: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> res0_r.last_result)
    else $error("single pending beat not marked last");

  a_last_two: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !res0_r.last_result && res1_r.last_result)
    else $error("pair of beats marked wrongly");

  // A new item never overwrites a beat that has not gone out.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))
    else $error("result buffer overrun");

endmodule
